FILE: rtl/core/ft12_pkg.sv
// ----------------------------------------------------------------------------
// ft12_pkg
// Shared types and constants for the FT1.2 frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ft12_pkg;

    localparam logic [7:0] START_VAR = 8'h68;
    localparam logic [7:0] START_FIX = 8'h10;
    localparam logic [7:0] END_MARK  = 8'h16;

    typedef enum logic [1:0] {
        KIND_VAR   = 2'd0,
        KIND_FIX   = 2'd1,
        KIND_OTHER = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LEN_DIFF  = 3'd1,
        ST_SIZE      = 3'd2,
        ST_START2    = 3'd3,
        ST_END       = 3'd4,
        ST_CHECKSUM  = 3'd5,
        ST_SHORT     = 3'd6
    } status_t;

    // Packed so that frame_kind lands in the lowest bits of the result word.
    typedef struct packed {
        logic [10:0] byte_count;
        logic [7:0]  control_byte;
        status_t     status;
        kind_t       frame_kind;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/ft12_acc.sv
// ----------------------------------------------------------------------------
// ft12_acc
// Chunk state accumulator and frame checks for one received byte per cycle with advance high.
// ----------------------------------------------------------------------------
`default_nettype none

module ft12_acc
    import ft12_pkg::*;
#(
    parameter int MAX_BYTES = 1024
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic [7:0] rx_byte,
    input  wire logic       last_byte,
    output result_t         result
);

    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    logic [CNT_W-1:0] idx_reg, idx_next, idx_kept;
    logic [7:0] lead_reg, lead_next, lead_kept;
    logic [7:0] len1_reg, len1_next, len1_kept;
    logic [7:0] len2_reg, len2_next, len2_kept;
    logic [7:0] start2_reg, start2_next, start2_kept;
    logic [7:0] ctrl_reg, ctrl_next, ctrl_kept;
    logic [7:0] usum_reg, usum_next, usum_kept;
    logic [7:0] fsum_reg, fsum_next, fsum_kept;
    logic [7:0] prev_reg, prev_next, prev_kept;
    logic [7:0] prev2_reg, prev2_next, prev2_kept;

    logic        take;
    logic [31:0] n_ext;
    status_t     var_status;
    status_t     fix_status;

    assign take = advance && (32'(idx_reg) < 32'(MAX_BYTES));

    // State after this byte is kept (bytes past the buffer size are dropped).
    always_comb begin
        idx_kept    = idx_reg;
        lead_kept   = lead_reg;
        len1_kept   = len1_reg;
        len2_kept   = len2_reg;
        start2_kept = start2_reg;
        ctrl_kept   = ctrl_reg;
        usum_kept   = usum_reg;
        fsum_kept   = fsum_reg;
        prev_kept   = prev_reg;
        prev2_kept  = prev2_reg;
        if (take) begin
            idx_kept   = idx_reg + CNT_W'(1);
            prev_kept  = rx_byte;
            prev2_kept = prev_reg;
            if (idx_reg == CNT_W'(0)) begin
                lead_kept = rx_byte;
            end
            if (idx_reg == CNT_W'(1)) begin
                len1_kept = rx_byte;
                if (lead_reg == START_FIX) begin
                    ctrl_kept = rx_byte;
                end
            end
            if (idx_reg == CNT_W'(2)) begin
                len2_kept = rx_byte;
            end
            if (idx_reg == CNT_W'(3)) begin
                start2_kept = rx_byte;
            end
            if (idx_reg == CNT_W'(4) && lead_reg == START_VAR) begin
                ctrl_kept = rx_byte;
            end
            if (idx_reg == CNT_W'(1) || idx_reg == CNT_W'(2)) begin
                fsum_kept = fsum_reg + rx_byte;
            end
            // The user sum trails by two bytes so checksum and end are never summed.
            if (idx_reg >= CNT_W'(6)) begin
                usum_kept = usum_reg + prev2_reg;
            end
        end
    end

    always_comb begin
        idx_next    = idx_reg;
        lead_next   = lead_reg;
        len1_next   = len1_reg;
        len2_next   = len2_reg;
        start2_next = start2_reg;
        ctrl_next   = ctrl_reg;
        usum_next   = usum_reg;
        fsum_next   = fsum_reg;
        prev_next   = prev_reg;
        prev2_next  = prev2_reg;
        if (advance) begin
            if (last_byte) begin
                idx_next    = '0;
                lead_next   = '0;
                len1_next   = '0;
                len2_next   = '0;
                start2_next = '0;
                ctrl_next   = '0;
                usum_next   = '0;
                fsum_next   = '0;
                prev_next   = '0;
                prev2_next  = '0;
            end else begin
                idx_next    = idx_kept;
                lead_next   = lead_kept;
                len1_next   = len1_kept;
                len2_next   = len2_kept;
                start2_next = start2_kept;
                ctrl_next   = ctrl_kept;
                usum_next   = usum_kept;
                fsum_next   = fsum_kept;
                prev_next   = prev_kept;
                prev2_next  = prev2_kept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            lead_reg   <= '0;
            len1_reg   <= '0;
            len2_reg   <= '0;
            start2_reg <= '0;
            ctrl_reg   <= '0;
            usum_reg   <= '0;
            fsum_reg   <= '0;
            prev_reg   <= '0;
            prev2_reg  <= '0;
        end else begin
            idx_reg    <= idx_next;
            lead_reg   <= lead_next;
            len1_reg   <= len1_next;
            len2_reg   <= len2_next;
            start2_reg <= start2_next;
            ctrl_reg   <= ctrl_next;
            usum_reg   <= usum_next;
            fsum_reg   <= fsum_next;
            prev_reg   <= prev_next;
            prev2_reg  <= prev2_next;
        end
    end

    assign n_ext = 32'(idx_kept);

    // The first failing check decides the status.
    always_comb begin
        if (n_ext < 32'd3) begin
            var_status = ST_SHORT;
        end else if (len1_kept != len2_kept) begin
            var_status = ST_LEN_DIFF;
        end else if (32'(len1_kept) + 32'd6 != n_ext) begin
            var_status = ST_SIZE;
        end else if (start2_kept != START_VAR) begin
            var_status = ST_START2;
        end else if (prev_kept != END_MARK) begin
            var_status = ST_END;
        end else if (prev2_kept != usum_kept) begin
            var_status = ST_CHECKSUM;
        end else begin
            var_status = ST_OK;
        end
    end

    always_comb begin
        if (n_ext < 32'd3) begin
            fix_status = ST_SHORT;
        end else if (prev_kept != END_MARK) begin
            fix_status = ST_END;
        end else if (prev2_kept != fsum_kept) begin
            fix_status = ST_CHECKSUM;
        end else begin
            fix_status = ST_OK;
        end
    end

    always_comb begin
        result.byte_count   = n_ext[10:0];
        result.control_byte = ctrl_kept;
        if (lead_kept == START_VAR) begin
            result.frame_kind = KIND_VAR;
            result.status     = var_status;
        end else if (lead_kept == START_FIX) begin
            result.frame_kind = KIND_FIX;
            result.status     = fix_status;
        end else begin
            result.frame_kind = KIND_OTHER;
            result.status     = ST_OK;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ft12_frame_checker_unit.sv
// A chunk's last byte passes the input register, then its result is registered.
// Throughput: one byte per cycle; a full, unread result register stops only a
// byte that closes a chunk. The input register, the 8-bit checksum adds and the
// result register set that figure.
// Reset: aresetn is synchronous and active low; it empties both registers and
// clears all chunk state.
// ----------------------------------------------------------------------------
// ft12_frame_checker_unit
// Checks link byte chunks as FT1.2 variable or fixed frames; others go unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module ft12_frame_checker_unit
    import ft12_pkg::*;
#(
    parameter int MAX_BYTES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
    input  wire logic        s_tlast,  // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // [1:0] frame_kind, [4:2] status,
                                       // [12:5] control_byte, [23:13] byte_count
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    res_reg;
    result_t    res_comb;
    logic       advance;

    // A byte only waits when it closes a chunk and the previous result is unread.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ft12_acc #(
        .MAX_BYTES(MAX_BYTES)
    ) u_acc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .rx_byte  (in_byte_reg),
        .last_byte(in_last_reg),
        .result   (res_comb)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ft12_frame_checker_unit_chk.sv
// ----------------------------------------------------------------------------
// ft12_frame_checker_unit_chk
// Port-level checks on the frame checker's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ft12_frame_checker_unit_chk
    import ft12_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined frame kind");

    a_other_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == KIND_OTHER |-> m_tdata[4:2] == ST_OK)
        else $error("unchecked chunk reported an error");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:13] != 11'd0)
        else $error("result for an empty chunk");

endmodule

bind ft12_frame_checker_unit ft12_frame_checker_unit_chk u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire

FILE: tb/ft12_frame_checker_unit_test.sv
// ----------------------------------------------------------------------------
// ft12_frame_checker_unit_test
// Drives link bytes into the FT1.2 frame checker and compares each closing
// result against a cycle-free prediction of the frame checks. Directed and random frames
// cover every status and the short, unchecked and overlong chunks; random
// chunks mix well-formed frames, corrupted frames and noise under random
// stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ft12_frame_checker_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ft12_pkg::*;

    localparam int FRAME_MAX    = 1024;
    localparam int RANDOM_WORDS = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    ft12_frame_checker_unit #(
        .MAX_BYTES(FRAME_MAX)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predicted chunk state, cleared after every closing byte.
    logic [10:0] rx_count;
    logic [7:0]  lead, len_a, len_b, start_b, ctrl, sum_user, sum_fix, last1, last2;

    result_t     pending_results[$];
    logic [7:0]  frame_buf[$];
    int unsigned words_sent     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          steady_phase   = 1'b0;
    result_t     observed;
    result_t     wanted;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void clear_chunk_state();
        rx_count = '0;
        lead     = '0;
        len_a    = '0;
        len_b    = '0;
        start_b  = '0;
        ctrl     = '0;
        sum_user = '0;
        sum_fix  = '0;
        last1    = '0;
        last2    = '0;
    endfunction

    function automatic void predict_frame_check(input logic [7:0] rx_byte,
                                                input logic last_byte);
        result_t outcome;
        if (rx_count < FRAME_MAX) begin
            if (rx_count == 0) lead = rx_byte;
            if (rx_count == 1) begin
                len_a = rx_byte;
                if (lead == START_FIX) ctrl = rx_byte;
            end
            if (rx_count == 2) len_b = rx_byte;
            if (rx_count == 3) start_b = rx_byte;
            if (rx_count == 4 && lead == START_VAR) ctrl = rx_byte;
            if (rx_count == 1 || rx_count == 2) sum_fix = sum_fix + rx_byte;
            // The user sum trails by two bytes so checksum and end are never added.
            if (rx_count >= 6) sum_user = sum_user + last2;
            last2 = last1;
            last1 = rx_byte;
            rx_count = rx_count + 1'b1;
        end
        if (last_byte) begin
            outcome.byte_count   = rx_count;
            outcome.control_byte = ctrl;
            if (lead == START_VAR) begin
                outcome.frame_kind = KIND_VAR;
                if (rx_count < 3)                          outcome.status = ST_SHORT;
                else if (len_a != len_b)                   outcome.status = ST_LEN_DIFF;
                else if (int'(len_a) + 6 != int'(rx_count)) outcome.status = ST_SIZE;
                else if (start_b != START_VAR)             outcome.status = ST_START2;
                else if (last1 != END_MARK)                outcome.status = ST_END;
                else if (last2 != sum_user)                outcome.status = ST_CHECKSUM;
                else                                       outcome.status = ST_OK;
            end else if (lead == START_FIX) begin
                outcome.frame_kind = KIND_FIX;
                if (rx_count < 3)             outcome.status = ST_SHORT;
                else if (last1 != END_MARK)   outcome.status = ST_END;
                else if (last2 != sum_fix)    outcome.status = ST_CHECKSUM;
                else                          outcome.status = ST_OK;
            end else begin
                outcome.frame_kind = KIND_OTHER;
                outcome.status     = ST_OK;
            end
            pending_results.push_back(outcome);
            clear_chunk_state();
        end
    endfunction

    // Sends one word; tvalid stays high into the next call unless it idles.
    task automatic send_word(input logic [7:0] rx_byte, input logic last_byte);
        while (!steady_phase && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx_byte;
        s_tlast  <= last_byte;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_frame_check(rx_byte, last_byte);
        words_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_word(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic void build_variable_frame(input int unsigned len);
        logic [7:0] user_byte;
        logic [7:0] sum;
        sum = '0;
        frame_buf.delete();
        frame_buf.push_back(START_VAR);
        frame_buf.push_back(len[7:0]);
        frame_buf.push_back(len[7:0]);
        frame_buf.push_back(START_VAR);
        repeat (len) begin
            user_byte = 8'($urandom_range(255));
            sum = sum + user_byte;
            frame_buf.push_back(user_byte);
        end
        frame_buf.push_back(sum);
        frame_buf.push_back(END_MARK);
    endfunction

    function automatic void build_fixed_frame();
        logic [7:0] control, address;
        control = 8'($urandom_range(255));
        address = 8'($urandom_range(255));
        frame_buf = '{START_FIX, control, address, 8'(control + address), END_MARK};
    endfunction

    function automatic void corrupt_frame();
        int unsigned pos;
        case ($urandom_range(3))
            0: begin
                pos = $urandom_range(frame_buf.size() - 1);
                frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
            end
            1: if (frame_buf.size() > 1) void'(frame_buf.pop_back());
            2: frame_buf.push_back(8'($urandom_range(255)));
            default: begin
                pos = frame_buf.size() - 2;
                frame_buf[pos] = frame_buf[pos] + 8'($urandom_range(1, 255));
            end
        endcase
    endfunction

    task automatic test_directed_frames();
        // Good frames with the byte extremes in the control, user and address fields.
        frame_buf = '{START_VAR, 8'h01, 8'h01, START_VAR, 8'hFF, 8'hFF, END_MARK};
        send_frame();
        frame_buf = '{START_FIX, 8'h00, 8'hFF, 8'hFF, END_MARK};
        send_frame();
        // Length bytes differ, control byte never received.
        frame_buf = '{START_VAR, 8'h01, 8'h02, START_VAR};
        send_frame();
        // A five-byte variable chunk with equal lengths can only fail the size check.
        frame_buf = '{START_VAR, 8'h00, 8'h00, START_VAR, 8'h00};
        send_frame();
        frame_buf = '{START_VAR, 8'h00, 8'h00, 8'h67, 8'h00, END_MARK};
        send_frame();
        // Chunks too short to check, and an unchecked leading byte.
        frame_buf = '{START_VAR};
        send_frame();
        frame_buf = '{START_FIX, END_MARK};
        send_frame();
        frame_buf = '{8'h80};
        send_frame();
        pause_until_drained();
    endtask

    task automatic test_overlong_chunk();
        // Bytes past the buffer size are dropped; the count saturates.
        frame_buf.delete();
        frame_buf.push_back(START_VAR);
        repeat (FRAME_MAX + 5) frame_buf.push_back(8'($urandom_range(255)));
        send_frame();
        pause_until_drained();
    endtask

    task automatic test_random_chunks();
        int unsigned chunk_no;
        int unsigned start_words;
        int unsigned pick;
        logic [7:0]  lead_pick;
        chunk_no    = 0;
        start_words = words_sent;
        while (words_sent - start_words < RANDOM_WORDS) begin
            steady_phase = (chunk_no >= 20 && chunk_no < 34);
            if (chunk_no == 12) pause_until_drained();
            pick = $urandom_range(99);
            if (pick < 45) begin
                build_variable_frame($urandom_range(9) == 0 ? $urandom_range(13, 255)
                                                            : $urandom_range(12));
                if ($urandom_range(99) < 30) corrupt_frame();
            end else if (pick < 75) begin
                build_fixed_frame();
                if ($urandom_range(99) < 30) corrupt_frame();
            end else if (pick < 87) begin
                frame_buf.delete();
                repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom_range(255)));
            end else begin
                do lead_pick = 8'($urandom_range(255));
                while (lead_pick == START_VAR || lead_pick == START_FIX);
                frame_buf.delete();
                frame_buf.push_back(lead_pick);
                repeat ($urandom_range(0, 6)) frame_buf.push_back(8'($urandom_range(255)));
            end
            send_frame();
            chunk_no++;
        end
        steady_phase = 1'b0;
    endtask

    task automatic note_mismatch(input string what, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%s: expected kind %0d status %0d ctrl %02h count %0d, ",
                      "got kind %0d status %0d ctrl %02h count %0d"},
                     what, want.frame_kind, want.status, want.control_byte, want.byte_count,
                     got.frame_kind, got.status, got.control_byte, got.byte_count);
    endtask

    always @(posedge aclk) begin
        m_tready <= steady_phase || ($urandom_range(99) >= 7);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            observed = result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                wanted = '0;
                note_mismatch("unexpected result word", wanted, observed);
            end else begin
                wanted = pending_results.pop_front();
                if (observed.frame_kind !== wanted.frame_kind ||
                    observed.status !== wanted.status ||
                    observed.control_byte !== wanted.control_byte ||
                    observed.byte_count !== wanted.byte_count)
                    note_mismatch("result mismatch", wanted, observed);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        clear_chunk_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_frames();
        test_overlong_chunk();
        test_random_chunks();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/ft12_pkg.sv
rtl/core/ft12_acc.sv
rtl/core/ft12_frame_checker_unit.sv
rtl/core/ft12_frame_checker_unit_chk.sv
tb/ft12_frame_checker_unit_test.sv
